/* design/fast_deflation_detector_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the fast deflation detector
// Shared property wrappers, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FAST_DEFLATION_DETECTOR_ASSERT_SVH
`define FAST_DEFLATION_DETECTOR_ASSERT_SVH

// same-cycle implication
`define FDD_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fdd assertion failed");

// delayed implication: consequent checked after the antecedent
`define FDD_ASSERT_DLY2(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error("fdd assertion failed");

`endif

/* design/fdd_pkg.sv */
// ---------------------------------------------------------------------------
// fdd_pkg
// Constants, codes and types shared by the fast deflation detector modules.
// ---------------------------------------------------------------------------
package fdd_pkg;

   localparam int NUM_WHEELS = 4;
   localparam int ADDR_W     = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

   localparam int PRES_W   = 8;
   localparam int SECS_W   = 7;
   localparam int GRAD_SH  = 6;
   localparam int NUM_W    = PRES_W + GRAD_SH;
   localparam int PROD_W   = (PRES_W + 1) + SECS_W;

   // input modes
   localparam logic [1:0] MODE_TELEGRAM = 2'd0;
   localparam logic [1:0] MODE_TICK     = 2'd1;
   localparam logic [1:0] MODE_CLEAR    = 2'd2;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_TOLERANCE = 2'd0;
   localparam logic [1:0] REG_WINDOW    = 2'd1;
   localparam logic [1:0] REG_GRADIENT  = 2'd2;

   localparam logic [PRES_W-1:0] TOLERANCE_RST = 8'd8;
   localparam logic [SECS_W-1:0] WINDOW_RST    = 7'd120;
   localparam logic [PRES_W-1:0] GRADIENT_RST  = 8'd8;

   typedef struct packed {
      logic [PRES_W-1:0] last_pressure;
      logic [SECS_W-1:0] seconds_left;
      logic              drop_seen;
      logic              warn_flag;
   } wheel_entry_type;

   typedef struct packed {
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      wheel_entry_type       wr_data;
   } mem_req_type;

endpackage

/* design/fdd_state_mem.sv */
// ---------------------------------------------------------------------------
// fdd_state_mem
// Per-wheel state memory, registered read; unwritten entries read as zero.
// ---------------------------------------------------------------------------
module fdd_state_mem (
   input  logic                    clock,
   input  logic                    reset,
   input  fdd_pkg::mem_req_type    mem_req,
   output fdd_pkg::wheel_entry_type rd_entry
);
   import fdd_pkg::*;

   wheel_entry_type           mem_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]     valid_ff;
   wheel_entry_type           rd_data_ff;
   logic                      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   // entries never written since reset read as zero via their valid bit
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* design/fast_deflation_detector.sv */
// ---------------------------------------------------------------------------
// fast_deflation_detector
// Per-wheel fast tyre deflation warning from pressure telegrams and ticks.
// ---------------------------------------------------------------------------
// Path from accept: telegram S_CALC, S_DEC, S_DONE; single-wheel clear
// S_SWEEP, S_DONE; tick and clear-all S_SWEEP once per wheel, then S_DONE;
// unused mode S_DONE. One item at a time: req_stall holds until S_DONE loads
// the output register, which waits while the result side is stalled.
// Reset (synchronous, high): config to tolerance 8, window 120, gradient 8;
// all wheel entries read as zero via per-entry valid bits.
// ---------------------------------------------------------------------------
`include "fast_deflation_detector_assert.svh"

module fast_deflation_detector (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_wheel_index,
   input  logic        req_all_wheels,
   input  logic [7:0]  req_pressure,
   input  logic        req_vehicle_moving,
   input  logic [7:0]  req_ref_min_pressure,
   input  logic [7:0]  req_release_pressure,
   input  logic        req_soft_warning_active,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_warning,
   output logic [7:0]  rsp_warn_level,
   // config port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fdd_pkg::*;

   // one-hot sequencer
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CALC  = 5'b00010,   // entry read back, gradient product formed
      S_DEC   = 5'b00100,   // telegram decision and write back
      S_SWEEP = 5'b01000,   // tick / clear read-modify-write
      S_DONE  = 5'b10000    // hand result to output register
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [PRES_W-1:0] tolerance_ff;
   logic [SECS_W-1:0] window_ff;
   logic [PRES_W-1:0] gradient_ff;
   logic              csr_wr;

   // latched item
   logic [1:0]        op_mode_ff;
   logic              op_all_ff;
   logic [PRES_W-1:0] op_p_ff;
   logic              op_moving_ff;
   logic [PRES_W-1:0] op_refmin_ff;
   logic [PRES_W-1:0] op_release_ff;
   logic              op_soft_ff;
   logic [ADDR_W-1:0] idx_ff, idx_in;

   // gradient stage
   wheel_entry_type   entry_ff;
   logic              pre_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [PROD_W-1:0] prod_ff;

   // result holding and output registers
   logic              res_warning_ff, res_warning_in;
   logic [PRES_W-1:0] res_level_ff, res_level_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_warning_ff;
   logic [PRES_W-1:0] rsp_level_ff;

   logic              accept;
   logic              tlg_accept;
   logic              wheel_ok;
   logic              sweep_last;
   logic              rsp_load;
   mem_req_type       mem_req;
   wheel_entry_type   rd_entry;

   // gradient math
   logic [SECS_W-1:0] elapsed;
   logic [PRES_W:0]   grad_plus1;
   logic              pre_in;

   // decision
   logic              steep;
   logic [PRES_W-1:0] park_limit;
   logic              dec_warning;
   logic              dec_write;
   logic [PRES_W-1:0] dec_level;
   wheel_entry_type   dec_entry;
   wheel_entry_type   sweep_entry;

   fdd_state_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_entry (rd_entry)
   );

   // ---------------- config port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RST;
         window_ff    <= WINDOW_RST;
         gradient_ff  <= GRADIENT_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_TOLERANCE: tolerance_ff <= csr_pwdata[PRES_W-1:0];
            REG_WINDOW:    window_ff    <= csr_pwdata[SECS_W-1:0];
            REG_GRADIENT:  gradient_ff  <= csr_pwdata[PRES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TOLERANCE: csr_prdata = 32'(tolerance_ff);
         REG_WINDOW:    csr_prdata = 32'(window_ff);
         REG_GRADIENT:  csr_prdata = 32'(gradient_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign wheel_ok  = (32'(req_wheel_index) < NUM_WHEELS);
   assign tlg_accept = accept && (req_mode == MODE_TELEGRAM) && wheel_ok;
   // single clear touches one entry; clear-all and tick walk every wheel
   assign sweep_last = (!op_all_ff) || (idx_ff == ADDR_W'(NUM_WHEELS - 1));
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // ---------------- gradient stage (S_CALC) ----------------
   // floor(num / elapsed) > limit  <=>  num >= (limit + 1) * elapsed
   assign elapsed    = window_ff - rd_entry.seconds_left;
   assign grad_plus1 = {1'b0, gradient_ff} + {{PRES_W{1'b0}}, 1'b1};
   assign pre_in     = (rd_entry.seconds_left != '0) &&
                       (rd_entry.seconds_left < window_ff) &&
                       (op_p_ff < rd_entry.last_pressure);

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC) begin
         entry_ff <= rd_entry;
         pre_ff   <= pre_in;
         num_ff   <= {rd_entry.last_pressure - op_p_ff, {GRAD_SH{1'b0}}};
         prod_ff  <= PROD_W'(grad_plus1) * PROD_W'(elapsed);
      end
   end

   // ---------------- telegram decision (S_DEC) ----------------
   assign steep      = pre_ff && (PROD_W'(num_ff) >= prod_ff);
   assign park_limit = (op_refmin_ff > tolerance_ff) ? (op_refmin_ff - tolerance_ff)
                                                     : tolerance_ff;

   always_comb begin
      dec_entry   = entry_ff;
      dec_level   = entry_ff.last_pressure;
      dec_warning = 1'b0;
      dec_write   = 1'b1;
      if (entry_ff.warn_flag && (op_p_ff <= op_release_ff)) begin
         // warning held, state untouched
         dec_warning = 1'b1;
         dec_write   = 1'b0;
      end else if (steep) begin
         dec_entry.last_pressure = op_p_ff;
         dec_entry.seconds_left  = window_ff;
         if (!entry_ff.drop_seen) begin
            dec_entry.drop_seen = 1'b1;
         end else if (op_soft_ff) begin
            if (op_moving_ff || (op_p_ff <= park_limit)) begin
               dec_entry.warn_flag = 1'b1;
               dec_warning         = 1'b1;
            end
         end
      end else begin
         // no steep drop: restart tracking from this pressure
         dec_entry.last_pressure = op_p_ff;
         dec_entry.seconds_left  = window_ff;
         dec_entry.drop_seen     = 1'b0;
         dec_entry.warn_flag     = 1'b0;
         dec_level               = op_p_ff;
      end
   end

   // ---------------- sweep modify ----------------
   always_comb begin
      sweep_entry = rd_entry;
      if (op_mode_ff == MODE_TICK) begin
         if (rd_entry.seconds_left != '0) begin
            sweep_entry.seconds_left = rd_entry.seconds_left - SECS_W'(1);
         end
      end else begin
         sweep_entry.last_pressure = '0;
      end
   end

   // ---------------- sequencer and memory port ----------------
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      res_warning_in = res_warning_ff;
      res_level_in   = res_level_ff;
      mem_req        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_warning_in = 1'b0;
               res_level_in   = '0;
               mem_req.rd_en  = 1'b1;
               case (req_mode)
                  MODE_TELEGRAM: begin
                     // wheel address kept for the write back
                     idx_in          = ADDR_W'(req_wheel_index);
                     mem_req.rd_addr = idx_in;
                     state_in        = wheel_ok ? S_CALC : S_DONE;
                  end
                  MODE_TICK: begin
                     idx_in   = '0;
                     state_in = S_SWEEP;
                  end
                  MODE_CLEAR: begin
                     if (req_all_wheels || !wheel_ok) begin
                        idx_in = '0;
                     end else begin
                        idx_in = ADDR_W'(req_wheel_index);
                     end
                     mem_req.rd_addr = idx_in;
                     state_in        = S_SWEEP;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CALC: begin
            state_in = S_DEC;
         end
         S_DEC: begin
            mem_req.wr_en   = dec_write;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = dec_entry;
            res_warning_in  = dec_warning;
            res_level_in    = dec_level;
            state_in        = S_DONE;
         end
         S_SWEEP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = sweep_entry;
            if (sweep_last) begin
               state_in = S_DONE;
            end else begin
               // next entry read while this one is written back
               idx_in          = idx_ff + ADDR_W'(1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_in;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      res_warning_ff <= res_warning_in;
      res_level_ff   <= res_level_in;
      if (accept) begin
         op_mode_ff    <= req_mode;
         op_all_ff     <= req_all_wheels || !wheel_ok || (req_mode == MODE_TICK);
         op_p_ff       <= req_pressure;
         op_moving_ff  <= req_vehicle_moving;
         op_refmin_ff  <= req_ref_min_pressure;
         op_release_ff <= req_release_pressure;
         op_soft_ff    <= req_soft_warning_active;
      end
      if (rsp_load) begin
         rsp_warning_ff <= res_warning_ff;
         rsp_level_ff   <= res_level_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_warning    = rsp_warning_ff;
   assign rsp_warn_level = rsp_level_ff;

   // ---------------- checks ----------------
   `FDD_ASSERT_IMP(a_no_write_idle, (state_ff == S_IDLE), !mem_req.wr_en)
   `FDD_ASSERT_DLY2(a_tlg_reaches_dec, tlg_accept, (state_ff == S_DEC))
   `FDD_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == S_DONE))
   `FDD_ASSERT_IMP(a_sweep_in_range, (state_ff == S_SWEEP), (32'(idx_ff) < NUM_WHEELS))

endmodule
